FILE: rtl/ckc_pkg.sv
// Package: shared types and constants for the coordinate-keyed stale cache.
package ckc_pkg;

  localparam int ENTRIES_DEF = 4096;

  localparam logic [31:0] PRIME_X     = 32'd73856093;
  localparam logic [31:0] PRIME_Y     = 32'd19349663;
  localparam logic [31:0] PRIME_Z     = 32'd83492791;
  localparam logic [31:0] STALE_RESET = 32'd60;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_FILL   = 2'd1,
    REQ_INVAL  = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    NB_SELF = 3'd0,
    NB_XP   = 3'd1,
    NB_XN   = 3'd2,
    NB_YP   = 3'd3,
    NB_YN   = 3'd4,
    NB_ZP   = 3'd5,
    NB_ZN   = 3'd6
  } nbr_t;

  typedef enum logic [1:0] {
    B_CLEAR = 2'd0,
    B_IDLE  = 2'd1,
    B_LOOK  = 2'd2,
    B_INVAL = 2'd3
  } back_state_t;

  typedef struct packed {
    req_t        kind;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [7:0]  sky;
    logic [7:0]  emit;
  } job_t;

  typedef struct packed {
    logic [31:0] tag_x;
    logic [31:0] tag_y;
    logic [31:0] tag_z;
    logic [7:0]  sky;
    logic [7:0]  emit;
    logic [31:0] stamp;
  } entry_t;

endpackage

FILE: rtl/coordinate_keyed_stale_cache_core.sv
// Top level: coordinate-keyed stale cache with config register, front end, queue and back end.
//
//   channel   ports                                   handshake
//   request   in_req_type in_pos_x/y/z in_sky_in      start high, busy low
//             in_emit_in
//   result    out_hit out_sky_out out_emit_out        out_valid, one cycle
//   config    cfg_wdata                               cfg_we
//
// A request beat is registered in the front end, then waits in a two-entry queue.
// The back end retires a fill or frame tick straight from idle, a lookup after a
// registered memory read, and an invalidate after one valid-bit write per touched entry.
// After reset, and after a tick that wraps the frame counter, busy stays high while
// the valid bits of all ENTRIES slots are swept clear.
// The receiver cannot stall; a result beat appears in the cycle after its request retires.
module coordinate_keyed_stale_cache_core #(
  parameter int ENTRIES = ckc_pkg::ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [7:0]         in_sky_in,
  input  logic [7:0]         in_emit_in,
  output logic               out_valid,
  output logic               out_hit,
  output logic [7:0]         out_sky_out,
  output logic [7:0]         out_emit_out,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  localparam int IW = $clog2(ENTRIES);
  localparam int QW = $bits(ckc_pkg::job_t) + 3 * IW;

  logic [31:0]        stale_r;
  logic               push, pop, fifo_full, fifo_empty, clearing;
  ckc_pkg::job_t      job, hd_job;
  logic [3*IW-1:0]    prod, hd_prod;
  logic [QW-1:0]      q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= ckc_pkg::STALE_RESET;
    end else if (cfg_we) begin
      stale_r <= cfg_wdata;
    end
  end

  ckc_front #(.ENTRIES(ENTRIES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .clearing    (clearing),
    .fifo_full   (fifo_full),
    .in_req_type (in_req_type),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .in_sky_in   (in_sky_in),
    .in_emit_in  (in_emit_in),
    .busy        (busy),
    .push        (push),
    .job         (job),
    .prod        (prod)
  );

  ckc_fifo #(.WIDTH(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .din   ({job, prod}),
    .dout  (q_dout),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  assign {hd_job, hd_prod} = q_dout;

  ckc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .fifo_empty   (fifo_empty),
    .hd_job       (hd_job),
    .hd_prod      (hd_prod),
    .stale_frames (stale_r),
    .pop          (pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_hit      (out_hit),
    .out_sky_out  (out_sky_out),
    .out_emit_out (out_emit_out)
  );

endmodule

FILE: rtl/ckc_front.sv
// Front end: accept request beats and register the hashed coordinate products.
module ckc_front #(
  parameter int ENTRIES = ckc_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          clearing,
  input  logic                          fifo_full,
  input  logic [1:0]                    in_req_type,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_pos_z,
  input  logic [7:0]                    in_sky_in,
  input  logic [7:0]                    in_emit_in,
  output logic                          busy,
  output logic                          push,
  output ckc_pkg::job_t                 job,
  output logic [3*$clog2(ENTRIES)-1:0]  prod
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] PXL = IW'(ckc_pkg::PRIME_X);
  localparam logic [IW-1:0] PYL = IW'(ckc_pkg::PRIME_Y);
  localparam logic [IW-1:0] PZL = IW'(ckc_pkg::PRIME_Z);

  logic            s1_vld_r, s1_vld_nxt;
  ckc_pkg::job_t   job_r;
  logic [IW-1:0]   px_r, py_r, pz_r;
  logic [IW-1:0]   px_nxt, py_nxt, pz_nxt;
  logic            accept;

  assign busy   = clearing || (s1_vld_r && fifo_full);
  assign accept = start && !busy;
  assign push   = s1_vld_r && !fifo_full;

  assign px_nxt = in_pos_x[IW-1:0] * PXL;
  assign py_nxt = in_pos_y[IW-1:0] * PYL;
  assign pz_nxt = in_pos_z[IW-1:0] * PZL;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (push) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r.kind  <= ckc_pkg::req_t'(in_req_type);
      job_r.pos_x <= in_pos_x;
      job_r.pos_y <= in_pos_y;
      job_r.pos_z <= in_pos_z;
      job_r.sky   <= in_sky_in;
      job_r.emit  <= in_emit_in;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      pz_r        <= pz_nxt;
    end
  end

  assign job  = job_r;
  assign prod = {px_r, py_r, pz_r};

endmodule

FILE: rtl/ckc_fifo.sv
// Two-entry queue between the front end and the back end.
module ckc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             pop,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = 2;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = ~wp_r;
    end
    if (pop) begin
      rp_nxt = ~rp_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

FILE: rtl/ckc_back.sv
// Back end: cache memories, frame counter and the per-request sequencer.
module ckc_back #(
  parameter int ENTRIES = ckc_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fifo_empty,
  input  ckc_pkg::job_t                 hd_job,
  input  logic [3*$clog2(ENTRIES)-1:0]  hd_prod,
  input  logic [31:0]                   stale_frames,
  output logic                          pop,
  output logic                          clearing,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [7:0]                    out_sky_out,
  output logic [7:0]                    out_emit_out
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] PXL = IW'(ckc_pkg::PRIME_X);
  localparam logic [IW-1:0] PYL = IW'(ckc_pkg::PRIME_Y);
  localparam logic [IW-1:0] PZL = IW'(ckc_pkg::PRIME_Z);

  ckc_pkg::entry_t       data_mem [ENTRIES];
  logic                  valid_mem [ENTRIES];

  ckc_pkg::back_state_t  state_r, state_nxt;
  ckc_pkg::nbr_t         step_r, step_nxt;
  logic [IW-1:0]         clr_r, clr_nxt;
  logic [31:0]           frame_r, frame_nxt, frame_inc;

  logic                  vld_out_r, hit_r, hit_nxt;
  logic [7:0]            sky_r, sky_nxt, emit_r, emit_nxt;

  ckc_pkg::entry_t       rd_entry_r, wr_entry;
  logic                  vld_rd_r;
  logic                  rd_en, dwe, vwe, vwdata;
  logic [IW-1:0]         vwaddr;

  logic [IW-1:0]         hd_px, hd_py, hd_pz;
  logic [IW-1:0]         px_s, py_s, pz_s, slot;
  logic [31:0]           age;
  logic                  fresh;

  assign {hd_px, hd_py, hd_pz} = hd_prod;

  always_comb begin
    px_s = hd_px;
    py_s = hd_py;
    pz_s = hd_pz;
    unique case (step_r)
      ckc_pkg::NB_SELF: ;
      ckc_pkg::NB_XP:   px_s = hd_px + PXL;
      ckc_pkg::NB_XN:   px_s = hd_px - PXL;
      ckc_pkg::NB_YP:   py_s = hd_py + PYL;
      ckc_pkg::NB_YN:   py_s = hd_py - PYL;
      ckc_pkg::NB_ZP:   pz_s = hd_pz + PZL;
      ckc_pkg::NB_ZN:   pz_s = hd_pz - PZL;
      default: ;
    endcase
    slot = px_s ^ py_s ^ pz_s;
  end

  assign wr_entry.tag_x = hd_job.pos_x;
  assign wr_entry.tag_y = hd_job.pos_y;
  assign wr_entry.tag_z = hd_job.pos_z;
  assign wr_entry.sky   = hd_job.sky;
  assign wr_entry.emit  = hd_job.emit;
  assign wr_entry.stamp = frame_r;

  assign frame_inc = frame_r + 32'd1;
  assign age       = frame_r - rd_entry_r.stamp;
  assign fresh     = vld_rd_r &&
                     (rd_entry_r.tag_x == hd_job.pos_x) &&
                     (rd_entry_r.tag_y == hd_job.pos_y) &&
                     (rd_entry_r.tag_z == hd_job.pos_z) &&
                     (age < stale_frames);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    clr_nxt   = clr_r;
    frame_nxt = frame_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    dwe       = 1'b0;
    vwe       = 1'b0;
    vwdata    = 1'b0;
    vwaddr    = slot;
    hit_nxt   = 1'b0;
    sky_nxt   = 8'd0;
    emit_nxt  = 8'd0;
    unique case (state_r)
      ckc_pkg::B_CLEAR: begin
        vwe     = 1'b1;
        vwaddr  = clr_r;
        clr_nxt = clr_r + IW'(1);
        if (&clr_r) begin
          state_nxt = ckc_pkg::B_IDLE;
        end
      end
      ckc_pkg::B_IDLE: begin
        if (!fifo_empty) begin
          unique case (hd_job.kind)
            ckc_pkg::REQ_LOOKUP: begin
              rd_en     = 1'b1;
              state_nxt = ckc_pkg::B_LOOK;
            end
            ckc_pkg::REQ_FILL: begin
              dwe    = 1'b1;
              vwe    = 1'b1;
              vwdata = 1'b1;
              pop    = 1'b1;
            end
            ckc_pkg::REQ_INVAL: begin
              vwe       = 1'b1;
              step_nxt  = ckc_pkg::NB_XP;
              state_nxt = ckc_pkg::B_INVAL;
            end
            ckc_pkg::REQ_TICK: begin
              frame_nxt = frame_inc;
              pop       = 1'b1;
              if (frame_inc == 32'd0) begin
                state_nxt = ckc_pkg::B_CLEAR;
              end
            end
            default: ;
          endcase
        end
      end
      ckc_pkg::B_LOOK: begin
        pop       = 1'b1;
        state_nxt = ckc_pkg::B_IDLE;
        if (fresh) begin
          hit_nxt  = 1'b1;
          sky_nxt  = rd_entry_r.sky;
          emit_nxt = rd_entry_r.emit;
        end
      end
      ckc_pkg::B_INVAL: begin
        vwe = 1'b1;
        if (step_r == ckc_pkg::NB_ZN) begin
          pop       = 1'b1;
          step_nxt  = ckc_pkg::NB_SELF;
          state_nxt = ckc_pkg::B_IDLE;
        end else begin
          step_nxt = ckc_pkg::nbr_t'(step_r + 3'd1);
        end
      end
      default: state_nxt = ckc_pkg::B_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ckc_pkg::B_CLEAR;
      step_r    <= ckc_pkg::NB_SELF;
      clr_r     <= '0;
      frame_r   <= 32'd0;
      vld_out_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      clr_r     <= clr_nxt;
      frame_r   <= frame_nxt;
      vld_out_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= hit_nxt;
    sky_r  <= sky_nxt;
    emit_r <= emit_nxt;
  end

  always_ff @(posedge clk) begin
    if (dwe) begin
      data_mem[slot] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= data_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      valid_mem[vwaddr] <= vwdata;
    end
    if (rd_en) begin
      vld_rd_r <= valid_mem[slot];
    end
  end

  assign clearing     = (state_r == ckc_pkg::B_CLEAR);
  assign out_valid    = vld_out_r;
  assign out_hit      = hit_r;
  assign out_sky_out  = sky_r;
  assign out_emit_out = emit_r;

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_empty)
    else $error("pop from empty queue");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ckc_pkg::B_CLEAR) |-> (!pop && !rd_en && !dwe))
    else $error("request serviced during clearing pass");

  a_lookup_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ckc_pkg::B_LOOK) |=> out_valid)
    else $error("lookup without result beat");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && state_r == ckc_pkg::B_IDLE && hd_job.kind == ckc_pkg::REQ_TICK)
      |=> (frame_r == $past(frame_r) + 32'd1))
    else $error("frame counter did not advance on tick");

  a_inval_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ckc_pkg::B_INVAL && step_r == ckc_pkg::NB_ZN) |-> pop)
    else $error("invalidate did not retire after last neighbor");

endmodule
